// File: sv/sorted_integer_set_macros.svh
// Assertion macros for the sorted integer set checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef SORTED_INTEGER_SET_MACROS_SVH
`define SORTED_INTEGER_SET_MACROS_SVH

// checked only out of reset
`define SIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/sis_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted integer set.
// No dependencies.
package sis_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 7;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } t_state;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
        logic clr;
    } t_cell_ctl;

endpackage

// File: sv/sis_cell.sv
`timescale 1ns / 1ps
// One cell of the ordered key chain: holds a key and its occupied bit.
// Depends on sis_pkg.
module sis_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sis_pkg::t_cell_ctl i_ctl,
    input  sis_pkg::t_key      i_key,
    input  sis_pkg::t_key      i_prev_key,
    input  logic               i_prev_lt,
    input  logic               i_prev_occ,
    input  sis_pkg::t_key      i_next_key,
    input  logic               i_next_occ,
    output sis_pkg::t_key      o_key,
    output logic               o_occ,
    output logic               o_lt,
    output logic               o_eq
);
    import sis_pkg::*;

    t_key r_key;
    logic r_occ;
    logic r_lt;
    logic r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.clr) begin
            r_occ <= 1'b0;
        end else if (i_ctl.ins) begin
            r_occ <= r_occ | i_prev_occ;
        end else if (i_ctl.rem && !r_lt) begin
            r_occ <= i_next_occ;
        end
    end

    // keys below the insert point stay; the insert point takes the new key,
    // cells above it take their lower neighbor's key
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_prev_lt ? i_key : i_prev_key;
        end else if (i_ctl.rem && !r_lt) begin
            r_key <= i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= r_occ && (r_key < i_key);
            r_eq <= r_occ && (r_key == i_key);
        end
    end

    assign o_key = r_key;
    assign o_occ = r_occ;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

// File: sv/sorted_integer_set.sv
`timescale 1ns / 1ps
// Sorted integer set: sequencer, result register and a chain of key cells.
// Depends on sis_pkg and sis_cell.
//
// channel   dir  handshake                     tdata fields (low bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready   cmd[1:0], key[33:2]
// m_axis    out  m_axis_tvalid/m_axis_tready   answer[0], status[1], occupancy[8:2]
//
// A request passes a compare state, where all cells compare against the key,
// then an apply state, where they shift or update and the result is loaded.
// A new request can be accepted in the apply state while results are taken.
// A held result stalls the update cycle; a request may still be accepted
// while the previous result waits. Reset (sync, active low) empties the set.
module sorted_integer_set #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // cmd[1:0], key[33:2], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // answer, status, occupancy[6:0], zero fill
);
    import sis_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_state r_state, n_state;
    t_cmd   r_cmd;
    t_key   r_key;
    logic [CW-1:0] r_count;
    logic   r_ovalid;
    logic   r_answer;
    logic   r_status;
    logic [OCC_W-1:0] r_occ_out;

    t_key w_key [CAPACITY];
    logic [CAPACITY-1:0] w_occ, w_lt, w_eq;

    t_cell_ctl w_ctl;
    logic w_accept, w_out_free, w_apply, w_cmp;
    logic w_found, w_full, w_ins, w_rem, w_answer, w_status;
    logic [CW-1:0] n_count;
    logic [CW+OCC_W-1:0] w_count_ext;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_CMP;
            ST_CMP:   n_state = ST_APPLY;
            ST_APPLY: begin
                if (w_out_free) n_state = w_accept ? ST_CMP : ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        w_apply       = 1'b0;
        w_cmp         = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_CMP:   w_cmp = 1'b1;
            ST_APPLY: begin
                s_axis_tready = w_out_free;
                w_apply       = w_out_free;
            end
            default:  s_axis_tready = 1'b0;
        endcase
    end

    assign w_found = |w_eq;
    assign w_full  = w_occ[CAPACITY-1];
    assign w_ins   = w_apply && (r_cmd == CMD_ADD) && !w_found && !w_full;
    assign w_rem   = w_apply && (r_cmd == CMD_REMOVE) && w_found;

    assign w_ctl.cmp = w_cmp;
    assign w_ctl.ins = w_ins;
    assign w_ctl.rem = w_rem;
    assign w_ctl.clr = w_apply && (r_cmd == CMD_CLEAR);

    always_comb begin
        w_answer = 1'b0;
        w_status = 1'b0;
        n_count  = r_count;
        case (r_cmd)
            CMD_ADD: begin
                w_answer = !w_found && !w_full;
                w_status = !w_found && w_full;
                if (!w_found && !w_full) n_count = r_count + CW'(1);
            end
            CMD_REMOVE: begin
                w_answer = w_found;
                if (w_found) n_count = r_count - CW'(1);
            end
            CMD_CONTAINS: w_answer = w_found;
            CMD_CLEAR: begin
                w_answer = 1'b1;
                n_count  = '0;
            end
            default: w_answer = 1'b0;
        endcase
    end

    assign w_count_ext = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(s_axis_tdata[1:0]);
            r_key <= t_key'(s_axis_tdata[33:2]);
        end
        if (w_apply) begin
            r_answer  <= w_answer;
            r_status  <= w_status;
            r_occ_out <= w_count_ext[OCC_W-1:0];
        end
    end

    // cell 0 sees an always-below, always-occupied neighbor on its low side;
    // the last cell sees an empty one on its high side
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key w_pk, w_nk;
        logic w_plt, w_pocc, w_nocc;
        if (g == 0) begin : g_lo
            assign w_pk   = r_key;
            assign w_plt  = 1'b1;
            assign w_pocc = 1'b1;
        end else begin : g_mid
            assign w_pk   = w_key[g-1];
            assign w_plt  = w_lt[g-1];
            assign w_pocc = w_occ[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign w_nk   = w_key[g];
            assign w_nocc = 1'b0;
        end else begin : g_top
            assign w_nk   = w_key[g+1];
            assign w_nocc = w_occ[g+1];
        end
        sis_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_prev_key (w_pk),
            .i_prev_lt  (w_plt),
            .i_prev_occ (w_pocc),
            .i_next_key (w_nk),
            .i_next_occ (w_nocc),
            .o_key      (w_key[g]),
            .o_occ      (w_occ[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'b0, r_occ_out, r_status, r_answer};

endmodule

// File: sv/sis_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the sorted integer set, bound to the top level.
// Depends on sorted_integer_set_macros.svh.
`include "sorted_integer_set_macros.svh"

module sis_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    `SIS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word dropped or changed while stalled")
    `SIS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "result word valid right after reset")
    `SIS_ASSERT(a_full_no_insert, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]), "full status with a true answer")
    `SIS_ASSERT(a_cmp_gap, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request word taken during compare cycle")

endmodule

bind sorted_integer_set sis_checker u_sis_checker (.*);
